// ----- rtl/binary_max_heap_queue_macros.svh -----
// Assertion shorthands for the heap queue. Clock clk, reset arst_n.
`ifndef BINARY_MAX_HEAP_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_MACROS_SVH

// cond must hold at every edge out of reset
`define BMHQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold at the edge after ante
`define BMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// cons must hold at the same edge as ante
`define BMHQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/bmhq_pkg.sv -----
package bmhq_pkg;

	localparam int KEY_W  = 32;
	localparam int CAP_W  = 7;
	localparam int ACT_W  = 2;
	localparam int STAT_W = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_DN_KEY,
		S_DN_CHK,
		S_DN_LEFT,
		S_DN_RIGHT,
		S_DN_CMP,
		S_FINISH
	} state_t;

endpackage

// ----- rtl/binary_max_heap_queue.sv -----
// Binary max-heap priority queue of signed 32-bit keys. Each item on the input
// channel is an insert (action 0), a pop of the maximum (action 1) or a peek
// (action 2, and the unused code 3); each gives exactly one result item with
// the maximum after the operation (zero when empty), a valid flag, the entry
// count and a status (0 done, 1 insert rejected because full, 2 pop rejected
// because empty). A rejected item leaves the heap untouched. The keys live in
// a MAX_ENTRIES x 32 memory with one write port and one registered read port,
// walked by a small sequencer around a single signed comparator; the root is
// mirrored in a register so peeks never touch the memory. The block takes one
// item at a time and drops ready while it works. A peek, a reject or a pop of
// the only entry needs no memory traffic. An insert climbs level by level,
// reading the parent, then comparing and writing; a pop moves the last entry
// to the root and sinks it with a left read, right read, compare and write per
// level on the one read port. A finished result waits in an output register;
// the next item is accepted while it waits. capacity_limit (the single config
// register, reset 64) caps the count at min(capacity_limit, MAX_ENTRIES); write
// it only while the block is idle. The key memory needs no clearing after
// reset: only entries below the count are ever used.

`include "binary_max_heap_queue_macros.svh"

module binary_max_heap_queue #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bmhq_pkg::CAP_W-1:0]          cfg_data,
	// request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [bmhq_pkg::ACT_W-1:0]          action,
	input  logic signed [bmhq_pkg::KEY_W-1:0]   value,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [bmhq_pkg::KEY_W-1:0]   top_value,
	output logic                                top_valid,
	output logic [bmhq_pkg::CAP_W-1:0]          entry_count,
	output logic [bmhq_pkg::STAT_W-1:0]         status
);

	// PW holds a 1-based heap position 1..MAX_ENTRIES, AW the memory address.
	localparam int PW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	// common width for the capacity compare
	localparam int CW = (PW > bmhq_pkg::CAP_W) ? PW : bmhq_pkg::CAP_W;
	localparam logic [CW-1:0] MAX_CW = CW'(MAX_ENTRIES);

	bmhq_pkg::state_t state_q, state_d;

	// control state
	logic [bmhq_pkg::CAP_W-1:0] capacity_q;
	logic [PW-1:0]              count_q;
	logic                       out_valid_q;

	// datapath
	logic [PW-1:0]                     pos_q;    // current hole
	logic [PW-1:0]                     cidx_q;   // chosen child position
	logic signed [bmhq_pkg::KEY_W-1:0] key_q;    // key being moved
	logic signed [bmhq_pkg::KEY_W-1:0] child_q;  // larger child so far
	logic signed [bmhq_pkg::KEY_W-1:0] top_q;    // copy of root entry
	logic [bmhq_pkg::STAT_W-1:0]       stat_q;

	logic signed [bmhq_pkg::KEY_W-1:0] top_value_q;
	logic                              top_valid_q;
	logic [bmhq_pkg::CAP_W-1:0]        entry_count_q;
	logic [bmhq_pkg::STAT_W-1:0]       status_q;

	// key memory
	logic signed [bmhq_pkg::KEY_W-1:0] mem_q [MAX_ENTRIES];
	logic signed [bmhq_pkg::KEY_W-1:0] rd_q;
	logic [PW-1:0]                     rd_pos;
	logic                              wr_en;
	logic [PW-1:0]                     wr_pos;
	logic signed [bmhq_pkg::KEY_W-1:0] wr_data;

	// shared comparator: cmp_a < cmp_b, signed
	logic signed [bmhq_pkg::KEY_W-1:0] cmp_a, cmp_b;
	logic                              cmp_lt;

	logic          accept;
	logic          full;
	logic [CW-1:0] cap_eff;
	logic [PW:0]   left_w;     // 2*pos, one bit wider
	logic          has_left;
	logic          has_right;
	logic          slot_free;

	assign accept    = in_valid && in_ready;
	assign cap_eff   = (CW'(capacity_q) > MAX_CW) ? MAX_CW : CW'(capacity_q);
	assign full      = CW'(count_q) >= cap_eff;
	assign left_w    = {pos_q, 1'b0};
	assign has_left  = left_w <= {1'b0, count_q};
	assign has_right = cidx_q < count_q;
	assign slot_free = !out_valid_q || out_ready;
	assign cmp_lt    = cmp_a < cmp_b;

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == bmhq_pkg::S_IDLE);
	assign out_valid   = out_valid_q;
	assign top_value   = top_value_q;
	assign top_valid   = top_valid_q;
	assign entry_count = entry_count_q;
	assign status      = status_q;

	// ---------------------------------------------------------------
	// next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				if (accept) begin
					case (action)
						bmhq_pkg::ACT_INSERT: state_d = full ? bmhq_pkg::S_FINISH
							: bmhq_pkg::S_UP_CHK;
						bmhq_pkg::ACT_POP: begin
							// popping the last entry needs no memory traffic
							if (count_q > PW'(1)) state_d = bmhq_pkg::S_DN_KEY;
							else state_d = bmhq_pkg::S_FINISH;
						end
						default: state_d = bmhq_pkg::S_FINISH;
					endcase
				end
			end
			bmhq_pkg::S_UP_CHK: begin
				if (pos_q == PW'(1)) state_d = bmhq_pkg::S_FINISH;
				else state_d = bmhq_pkg::S_UP_CMP;
			end
			bmhq_pkg::S_UP_CMP: begin
				if (cmp_lt) state_d = bmhq_pkg::S_UP_CHK;
				else state_d = bmhq_pkg::S_FINISH;
			end
			bmhq_pkg::S_DN_KEY: state_d = bmhq_pkg::S_DN_CHK;
			bmhq_pkg::S_DN_CHK: begin
				if (has_left) state_d = bmhq_pkg::S_DN_LEFT;
				else state_d = bmhq_pkg::S_FINISH;
			end
			bmhq_pkg::S_DN_LEFT: begin
				if (has_right) state_d = bmhq_pkg::S_DN_RIGHT;
				else state_d = bmhq_pkg::S_DN_CMP;
			end
			bmhq_pkg::S_DN_RIGHT: state_d = bmhq_pkg::S_DN_CMP;
			bmhq_pkg::S_DN_CMP: begin
				if (cmp_lt) state_d = bmhq_pkg::S_DN_CHK;
				else state_d = bmhq_pkg::S_FINISH;
			end
			bmhq_pkg::S_FINISH: begin
				if (slot_free) state_d = bmhq_pkg::S_IDLE;
			end
			default: state_d = bmhq_pkg::S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// memory port and comparator operand selection
	// ---------------------------------------------------------------
	always_comb begin
		rd_pos  = count_q;           // idle: last entry, for a pop
		wr_en   = 1'b0;
		wr_pos  = pos_q;
		wr_data = key_q;
		cmp_a   = key_q;
		cmp_b   = child_q;
		case (state_q)
			bmhq_pkg::S_UP_CHK: begin
				rd_pos = pos_q >> 1;
				// reached the root: the key lands here
				wr_en  = (pos_q == PW'(1));
			end
			bmhq_pkg::S_UP_CMP: begin
				cmp_a   = rd_q;      // parent
				cmp_b   = key_q;
				wr_en   = 1'b1;
				wr_data = cmp_lt ? rd_q : key_q;
			end
			bmhq_pkg::S_DN_CHK: begin
				rd_pos = left_w[PW-1:0];
				wr_en  = !has_left;
			end
			bmhq_pkg::S_DN_LEFT: begin
				rd_pos = cidx_q + PW'(1);
			end
			bmhq_pkg::S_DN_RIGHT: begin
				cmp_a = child_q;     // left < right picks right
				cmp_b = rd_q;
			end
			bmhq_pkg::S_DN_CMP: begin
				cmp_a   = key_q;
				cmp_b   = child_q;
				wr_en   = 1'b1;
				wr_data = cmp_lt ? child_q : key_q;
			end
			default: begin
				rd_pos = count_q;
			end
		endcase
	end

	// memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[AW'(wr_pos - PW'(1))] <= wr_data;
		end
		rd_q <= mem_q[AW'(rd_pos - PW'(1))];
	end

	// ---------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmhq_pkg::S_IDLE;
			capacity_q  <= bmhq_pkg::CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			if (accept) begin
				if (action == bmhq_pkg::ACT_INSERT && !full) begin
					count_q <= count_q + PW'(1);
				end else if (action == bmhq_pkg::ACT_POP && count_q != '0) begin
					count_q <= count_q - PW'(1);
				end
			end
			if (state_q == bmhq_pkg::S_FINISH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// datapath registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (wr_en && wr_pos == PW'(1)) begin
			top_q <= wr_data;
		end
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				if (accept) begin
					key_q  <= value;
					pos_q  <= (action == bmhq_pkg::ACT_INSERT) ? count_q + PW'(1)
						: PW'(1);
					if (action == bmhq_pkg::ACT_INSERT && full) begin
						stat_q <= bmhq_pkg::ST_FULL;
					end else if (action == bmhq_pkg::ACT_POP && count_q == '0) begin
						stat_q <= bmhq_pkg::ST_EMPTY;
					end else begin
						stat_q <= bmhq_pkg::ST_DONE;
					end
				end
			end
			bmhq_pkg::S_UP_CMP: begin
				if (cmp_lt) pos_q <= pos_q >> 1;
			end
			bmhq_pkg::S_DN_KEY: key_q <= rd_q;   // former last entry
			bmhq_pkg::S_DN_CHK: cidx_q <= left_w[PW-1:0];
			bmhq_pkg::S_DN_LEFT: child_q <= rd_q;
			bmhq_pkg::S_DN_RIGHT: begin
				if (cmp_lt) begin
					child_q <= rd_q;
					cidx_q  <= cidx_q + PW'(1);
				end
			end
			bmhq_pkg::S_DN_CMP: begin
				if (cmp_lt) pos_q <= cidx_q;
			end
			bmhq_pkg::S_FINISH: begin
				if (slot_free) begin
					top_value_q   <= (count_q != '0) ? top_q : '0;
					top_valid_q   <= (count_q != '0);
					entry_count_q <= bmhq_pkg::CAP_W'(count_q);
					status_q      <= stat_q;
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	`BMHQ_ASSERT_ALWAYS(a_count_in_range, CW'(count_q) <= MAX_CW, "count above storage")
	`BMHQ_ASSERT_SAME(a_write_in_heap, wr_en, (wr_pos != '0) && (wr_pos <= count_q), "write outside heap")
	`BMHQ_ASSERT_NEXT(a_full_keeps_count, accept && action == bmhq_pkg::ACT_INSERT && full, count_q == $past(count_q), "rejected insert changed count")
	`BMHQ_ASSERT_NEXT(a_result_waits, out_valid_q && !out_ready, out_valid_q && $stable(status_q), "result lost before taken")

endmodule

// ----- test/binary_max_heap_queue_tb.sv -----
module binary_max_heap_queue_tb;
	import bmhq_pkg::*;

	localparam int HEAP_DEPTH  = 64;
	localparam int CYCLE_LIMIT = 600000;
	// drain time after the last result; longer than the slowest pop
	localparam int TAIL_CYCLES = 40;
	localparam int PRINT_LIMIT = 40;
	// the unused action code; the block treats it as a peek
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

	typedef struct {
		logic [KEY_W-1:0]  top;
		logic              valid;
		logic [CAP_W-1:0]  count;
		logic [STAT_W-1:0] stat;
	} heap_reply_t;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CAP_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [ACT_W-1:0]         action = ACT_PEEK;
	logic signed [KEY_W-1:0]  value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [KEY_W-1:0]  top_value;
	logic                     top_valid;
	logic [CAP_W-1:0]         entry_count;
	logic [STAT_W-1:0]        status;

	// shadow copy of the heap, its count and the capacity register
	logic signed [KEY_W-1:0]  shadow_keys [1:HEAP_DEPTH];
	int                       shadow_count;
	int                       shadow_cap;

	heap_reply_t              replies_due[$];

	int sender_idle_pct;
	int receiver_idle_pct;
	int mismatch_count;
	int items_sent;
	int replies_checked;
	int full_rejects;
	int empty_rejects;
	int deepest_count;
	int cap_writes;
	int cycle_count;

	binary_max_heap_queue #(
		.MAX_ENTRIES(HEAP_DEPTH)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.top_value  (top_value),
		.top_valid  (top_valid),
		.entry_count(entry_count),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d replies outstanding",
			cycle_count, replies_due.size());
		$display("binary_max_heap_queue_tb failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_LIMIT)
			$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	// Applies one request to the shadow heap and returns the reply it gives.
	// Insert swims the new key up past smaller parents; pop moves the last
	// key to the root and sinks it toward the larger child, left on a tie.
	function automatic heap_reply_t heap_apply_request(input logic [ACT_W-1:0] act,
			input logic signed [KEY_W-1:0] key);
		heap_reply_t             r;
		int                      eff_cap;
		int                      k;
		int                      c;
		logic signed [KEY_W-1:0] tmp;
		eff_cap = (shadow_cap > HEAP_DEPTH) ? HEAP_DEPTH : shadow_cap;
		r.stat = ST_DONE;
		if (act == ACT_INSERT) begin
			if (shadow_count >= eff_cap) begin
				r.stat = ST_FULL;
			end else begin
				shadow_count++;
				shadow_keys[shadow_count] = key;
				k = shadow_count;
				while (k > 1 && shadow_keys[k / 2] < shadow_keys[k]) begin
					tmp = shadow_keys[k];
					shadow_keys[k] = shadow_keys[k / 2];
					shadow_keys[k / 2] = tmp;
					k = k / 2;
				end
			end
		end else if (act == ACT_POP) begin
			if (shadow_count == 0) begin
				r.stat = ST_EMPTY;
			end else begin
				tmp = shadow_keys[1];
				shadow_keys[1] = shadow_keys[shadow_count];
				shadow_keys[shadow_count] = tmp;
				shadow_count--;
				k = 1;
				while (2 * k <= shadow_count) begin
					c = 2 * k;
					if (c < shadow_count && shadow_keys[c] < shadow_keys[c + 1])
						c++;
					if (!(shadow_keys[k] < shadow_keys[c]))
						break;
					tmp = shadow_keys[k];
					shadow_keys[k] = shadow_keys[c];
					shadow_keys[c] = tmp;
					k = c;
				end
			end
		end
		r.valid = (shadow_count != 0);
		r.top   = (shadow_count != 0) ? shadow_keys[1] : '0;
		r.count = shadow_count[CAP_W-1:0];
		return r;
	endfunction

	// Presents one item and returns at the edge where it is taken. Valid is
	// left high afterwards; the next call or wait_drained decides its fate.
	task automatic send_request(input logic [ACT_W-1:0] act, input logic signed [KEY_W-1:0] key);
		heap_reply_t r;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		value    <= key;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = heap_apply_request(act, key);
		replies_due.push_back(r);
		items_sent++;
		if (r.stat == ST_FULL)
			full_rejects++;
		if (r.stat == ST_EMPTY)
			empty_rejects++;
		if (shadow_count > deepest_count)
			deepest_count = shadow_count;
	endtask

	// always moves past at least one edge, so callers never drive twice in a step
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (replies_due.size() != 0);
	endtask

	// capacity may only change while the block has nothing in flight
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		shadow_cap = cap;
		cap_writes++;
	endtask

	// mostly wide random keys, with extremes and a narrow band for ties
	function automatic logic signed [KEY_W-1:0] random_key();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return int'($urandom_range(0, 7)) - 4;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CAP_W-1:0] pick_capacity();
		case ($urandom_range(5))
			0, 5: return CAP_RESET;
			1: return 7'd127;
			2: return CAP_W'($urandom_range(1, 63));
			3: return CAP_W'($urandom_range(65, 126));
			default: begin
				// lower below what is held so inserts bounce while pops go on
				if (shadow_count > 1)
					return CAP_W'($urandom_range(0, shadow_count - 1));
				return CAP_W'($urandom_range(1, 8));
			end
		endcase
	endfunction

	// Reply side: check each taken reply, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			replies_checked++;
			if (replies_due.size() == 0) begin
				report_mismatch($sformatf("reply with none pending: top %0d count %0d status %0d",
					top_value, entry_count, status));
			end else begin
				heap_reply_t want;
				want = replies_due.pop_front();
				if (top_value !== want.top)
					report_mismatch($sformatf("top_value %0d, want %0d",
						top_value, $signed(want.top)));
				if (top_valid !== want.valid)
					report_mismatch($sformatf("top_valid %b, want %b", top_valid, want.valid));
				if (entry_count !== want.count)
					report_mismatch($sformatf("entry_count %0d, want %0d",
						entry_count, want.count));
				if (status !== want.stat)
					report_mismatch($sformatf("status %0d, want %0d", status, want.stat));
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= receiver_idle_pct);
	end

	// peek, spare code and pop on a queue that holds nothing
	task automatic test_empty_queue();
		send_request(ACT_PEEK, 32'sd5);
		send_request(ACT_SPARE, -32'sd1);
		send_request(ACT_POP, 32'sh7fffffff);
	endtask

	// extremes of the key range, a duplicate maximum, then drain in order
	task automatic test_key_extremes();
		send_request(ACT_INSERT, 32'sd0);
		send_request(ACT_INSERT, 32'sh7fffffff);
		send_request(ACT_INSERT, 32'sh80000000);
		send_request(ACT_INSERT, -32'sd1);
		send_request(ACT_INSERT, 32'sd1);
		send_request(ACT_INSERT, 32'sh7fffffff);
		send_request(ACT_PEEK, 32'sh80000000);
		repeat (6)
			send_request(ACT_POP, 32'sd0);
		send_request(ACT_POP, 32'sd0);
	endtask

	// zero capacity rejects every insert; capacity one takes a single key
	task automatic test_small_capacity();
		write_capacity(7'd0);
		send_request(ACT_INSERT, 32'sd42);
		send_request(ACT_PEEK, 32'sd0);
		write_capacity(7'd1);
		send_request(ACT_INSERT, -32'sd7);
		send_request(ACT_INSERT, 32'sd9);
		send_request(ACT_POP, 32'sd0);
	endtask

	// Capacity above storage is clamped to the array size. Then the limit
	// is dropped under the count: inserts bounce, pops still drain the heap.
	task automatic test_fill_past_storage();
		write_capacity(7'd127);
		repeat (HEAP_DEPTH + 1)
			send_request(ACT_INSERT, random_key());
		write_capacity(7'd3);
		send_request(ACT_INSERT, 32'sd100);
		repeat (HEAP_DEPTH)
			send_request(ACT_POP, random_key());
		send_request(ACT_POP, 32'sd0);
		write_capacity(CAP_RESET);
	endtask

	// Bursts leaning toward inserts or pops walk the count up to full and
	// back down; capacity changes between segments.
	task automatic run_random_traffic(input int n_items, input int send_pct, input int recv_pct);
		int               done_items;
		int               seg_end;
		int               burst;
		int               insert_pct;
		int               r;
		logic [ACT_W-1:0] act;
		sender_idle_pct   = send_pct;
		receiver_idle_pct = recv_pct;
		done_items = 0;
		while (done_items < n_items) begin
			write_capacity(pick_capacity());
			seg_end = done_items + 100;
			while (done_items < seg_end && done_items < n_items) begin
				burst = $urandom_range(8, 48);
				case ($urandom_range(2))
					0: insert_pct = 80;
					1: insert_pct = 25;
					default: insert_pct = 50;
				endcase
				repeat (burst) begin
					if (done_items >= n_items)
						break;
					r = $urandom_range(99);
					if (r < insert_pct)
						act = ACT_INSERT;
					else if (r < 94)
						act = ACT_POP;
					else if (r < 98)
						act = ACT_PEEK;
					else
						act = ACT_SPARE;
					send_request(act, random_key());
					done_items++;
				end
			end
		end
	endtask

	initial begin
		mismatch_count  = 0;
		items_sent      = 0;
		replies_checked = 0;
		full_rejects    = 0;
		empty_rejects   = 0;
		deepest_count   = 0;
		cap_writes      = 0;
		shadow_count    = 0;
		shadow_cap      = CAP_RESET;
		sender_idle_pct   = 33;
		receiver_idle_pct = 51;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_key_extremes();
		test_small_capacity();
		test_fill_past_storage();

		run_random_traffic(550, 33, 51);
		run_random_traffic(550, 51, 33);
		run_random_traffic(500, 0, 0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests and %0d replies over %0d capacity settings",
			items_sent, replies_checked, cap_writes);
		$display("heap reached %0d entries; %0d full and %0d empty rejections",
			deepest_count, full_rejects, empty_rejects);
		if (replies_due.size() != 0)
			report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
		if (mismatch_count == 0) begin
			$display("binary_max_heap_queue_tb passed");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("binary_max_heap_queue_tb failed");
		end
		$finish;
	end

endmodule
